>>> sv/swst_pkg.sv
package swst_pkg;

  localparam int unsigned ValW   = 8;
  localparam int unsigned ErrW   = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  localparam logic [ValW-1:0] BasePeriodRst    = 8'd30;
  localparam logic [ValW-1:0] WallThresholdRst = 8'd15;
  localparam logic            CorrEnableRst    = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    RegBasePeriod       = 2'd0,
    RegWallThreshold    = 2'd1,
    RegCorrectionEnable = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KindTick   = 1'b0,
    KindSensor = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [ValW-1:0] base_period;
    logic [ValW-1:0] wall_threshold;
    logic            correction_enable;
  } cfg_t;

  typedef struct packed {
    logic [ValW-1:0] left_lit;
    logic [ValW-1:0] left_dark;
    logic [ValW-1:0] right_lit;
    logic [ValW-1:0] right_dark;
  } sensor_t;

  typedef struct packed {
    item_kind_e kind;
    logic       right_enable;
    logic       left_enable;
    sensor_t    sensor;
  } item_t;

  typedef struct packed {
    logic [ValW-1:0]        left_period_now;
    logic [ValW-1:0]        right_period_now;
    logic signed [ErrW-1:0] steer_error;
    logic                   left_stepped;
    logic                   right_stepped;
    logic [ValW-1:0]        left_pattern;
    logic [ValW-1:0]        right_pattern;
  } result_t;

  function automatic logic [ValW-1:0] coil_pattern(input logic [1:0] phase);
    logic [ValW-1:0] pat;
    case (phase)
      2'd0: pat = 8'h99;
      2'd1: pat = 8'h33;
      2'd2: pat = 8'h66;
      2'd3: pat = 8'hCC;
      default: pat = 8'h99;
    endcase
    return pat;
  endfunction

endpackage

>>> sv/swst_motor.sv
module swst_motor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tick_i,
  input  logic                         enable_i,
  input  logic [swst_pkg::ValW-1:0]    period_i,
  output logic                         stepped_o,
  output logic [swst_pkg::ValW-1:0]    pattern_o
);

  logic [swst_pkg::ValW-1:0] ticks_q, ticks_d, ticks_inc;
  logic [1:0]                phase_q, phase_d;
  logic [swst_pkg::ValW-1:0] drive_q, drive_d;

  always_comb begin
    ticks_inc = ticks_q + 8'd1;
    stepped_o = tick_i && enable_i && (ticks_inc > period_i);
    ticks_d   = ticks_q;
    phase_d   = phase_q;
    drive_d   = drive_q;
    if (tick_i) begin
      ticks_d = ticks_inc;
    end
    if (stepped_o) begin
      ticks_d = '0;
      drive_d = swst_pkg::coil_pattern(phase_q);
      phase_d = phase_q + 2'd1;
    end
  end

  assign pattern_o = drive_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= '0;
      phase_q <= '0;
      drive_q <= '0;
    end else begin
      ticks_q <= ticks_d;
      phase_q <= phase_d;
      drive_q <= drive_d;
    end
  end

endmodule

>>> sv/swst_steer.sv
module swst_steer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               update_i,
  input  swst_pkg::sensor_t                  sensor_i,
  input  swst_pkg::cfg_t                     cfg_i,
  output logic signed [swst_pkg::ErrW-1:0]   error_o,
  output logic [swst_pkg::ValW-1:0]          right_period_o,
  output logic [swst_pkg::ValW-1:0]          left_period_o
);

  logic [swst_pkg::ValW-1:0] centre_q, centre_d;
  logic [swst_pkg::ErrW-1:0] error_q, error_d;
  logic [swst_pkg::ValW-1:0] rper_q, rper_d, lper_q, lper_d;

  logic [swst_pkg::ValW-1:0] lv, rv, op_a, op_b, sat;
  logic [swst_pkg::ValW:0]   sum, stretch;
  logic [swst_pkg::ValW+1:0] diff, mag;

  always_comb begin
    lv = (sensor_i.left_lit > sensor_i.left_dark)
       ? sensor_i.left_lit - sensor_i.left_dark : '0;
    rv = (sensor_i.right_lit > sensor_i.right_dark)
       ? sensor_i.right_lit - sensor_i.right_dark : '0;

    // left wall missing wins over right wall missing
    if (lv < cfg_i.wall_threshold) begin
      op_a = centre_q;
      op_b = rv;
    end else if (rv < cfg_i.wall_threshold) begin
      op_a = lv;
      op_b = centre_q;
    end else begin
      op_a = lv;
      op_b = rv;
    end

    diff    = {2'b00, op_a} - {2'b00, op_b};
    sum     = {1'b0, op_a} + {1'b0, op_b};
    mag     = diff[swst_pkg::ValW+1] ? (~diff + 10'd1) : diff;
    stretch = {1'b0, cfg_i.base_period} + {4'b0000, mag[swst_pkg::ValW-1:3]};
    sat     = stretch[swst_pkg::ValW] ? 8'hFF : stretch[swst_pkg::ValW-1:0];

    centre_d = centre_q;
    error_d  = error_q;
    rper_d   = rper_q;
    lper_d   = lper_q;
    if (update_i) begin
      centre_d = sum[swst_pkg::ValW:1];
      error_d  = diff[swst_pkg::ErrW-1:0];
      if (cfg_i.correction_enable && (diff != '0)) begin
        if (diff[swst_pkg::ValW+1]) begin
          lper_d = sat;
        end else begin
          rper_d = sat;
        end
      end
    end
  end

  assign error_o        = $signed(error_d);
  assign right_period_o = rper_d;
  assign left_period_o  = lper_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q <= '0;
      error_q  <= '0;
      rper_q   <= swst_pkg::BasePeriodRst;
      lper_q   <= swst_pkg::BasePeriodRst;
    end else begin
      centre_q <= centre_d;
      error_q  <= error_d;
      rper_q   <= rper_d;
      lper_q   <= lper_d;
    end
  end

endmodule

>>> sv/stepper_pair_wall_steering.sv
// Twin stepper drive steered by two side wall sensors.
// Input channel s_axis: one word per tick or sensor sample, tuser says which.
// Output channel m_axis: one result word for every input word, in order,
// carrying both coil patterns, step flags, the latest steering error and
// both current step periods.
// Config channel cfg: register index and data, taken in the cycle it is
// valid (cfg_ready_o is always high); write only while the block is idle.
// The input word is registered in the input register and its result in
// the result register, which drives m_axis.
// Throughput: one word per clock while the receiver takes results; the
// whole update is single-pass logic between the input and result registers.
// Reset: coil patterns, counters, phases, centre level and error clear,
// both periods and base period go to 30, threshold 15, correction on.
// When the receiver stalls the result register holds; the input register
// still takes one more word, then s_axis_tready drops until space frees.
module stepper_pair_wall_steering (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // right_enable, left_enable, left_lit, left_dark, right_lit, right_dark, pad
  input  logic [swst_pkg::InDataW-1:0]           s_axis_tdata,
  // kind
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // right_pattern, left_pattern, right_stepped, left_stepped, steer_error,
  // right_period_now, left_period_now, pad
  output logic [swst_pkg::OutDataW-1:0]          m_axis_tdata,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [swst_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [swst_pkg::ValW-1:0]              cfg_data_i
);

  swst_pkg::cfg_t    cfg_q;
  swst_pkg::item_t   in_q;
  swst_pkg::result_t res_d, res_q;
  logic              in_valid_q, out_valid_q;
  logic              out_free, fire, tick, sample;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_period       <= swst_pkg::BasePeriodRst;
      cfg_q.wall_threshold    <= swst_pkg::WallThresholdRst;
      cfg_q.correction_enable <= swst_pkg::CorrEnableRst;
    end else if (cfg_valid_i) begin
      case (swst_pkg::cfg_reg_e'(cfg_index_i))
        swst_pkg::RegBasePeriod:       cfg_q.base_period       <= cfg_data_i;
        swst_pkg::RegWallThreshold:    cfg_q.wall_threshold    <= cfg_data_i;
        swst_pkg::RegCorrectionEnable: cfg_q.correction_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign tick          = fire && (in_q.kind == swst_pkg::KindTick);
  assign sample        = fire && (in_q.kind == swst_pkg::KindSensor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.kind                <= swst_pkg::item_kind_e'(s_axis_tuser);
      in_q.right_enable        <= s_axis_tdata[0];
      in_q.left_enable         <= s_axis_tdata[1];
      in_q.sensor.left_lit     <= s_axis_tdata[9:2];
      in_q.sensor.left_dark    <= s_axis_tdata[17:10];
      in_q.sensor.right_lit    <= s_axis_tdata[25:18];
      in_q.sensor.right_dark   <= s_axis_tdata[33:26];
    end
  end

  swst_steer u_steer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .update_i       (sample),
    .sensor_i       (in_q.sensor),
    .cfg_i          (cfg_q),
    .error_o        (res_d.steer_error),
    .right_period_o (res_d.right_period_now),
    .left_period_o  (res_d.left_period_now)
  );

  swst_motor u_motor_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .enable_i  (in_q.right_enable),
    .period_i  (res_d.right_period_now),
    .stepped_o (res_d.right_stepped),
    .pattern_o (res_d.right_pattern)
  );

  swst_motor u_motor_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .enable_i  (in_q.left_enable),
    .period_i  (res_d.left_period_now),
    .stepped_o (res_d.left_stepped),
    .pattern_o (res_d.left_pattern)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, res_q.left_period_now, res_q.right_period_now,
                          res_q.steer_error, res_q.left_stepped, res_q.right_stepped,
                          res_q.left_pattern, res_q.right_pattern};

  // a held input word is not dropped while the result register is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q)
    else $error("input word lost under stall");

  // every word that moves on produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result missing after advance");

  // sensor samples never step a motor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample |=> !res_q.right_stepped && !res_q.left_stepped)
    else $error("motor stepped on sensor word");

  // ticks leave the steering error as it was
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick ##1 fire && (in_q.kind == swst_pkg::KindTick) |=>
      res_q.steer_error == $past(res_q.steer_error))
    else $error("steering error changed on tick");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int ResW = $bits(swst_pkg::result_t);
  localparam logic [swst_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  // scoreboard: own copy of the drive and steering state
  class steer_scoreboard;
    logic [swst_pkg::ValW-1:0] base_period, wall_level;
    logic corr_on;
    logic [swst_pkg::ValW-1:0] r_ticks, l_ticks, r_drive, l_drive, r_period, l_period, centre;
    logic [1:0] r_phase, l_phase;
    logic signed [swst_pkg::ErrW-1:0] last_err;
    swst_pkg::result_t pending_words[$];
    int mismatches, checked, ticks_seen, samples_seen, r_steps, l_steps;

    function new();
      base_period = 8'd30;
      wall_level = 8'd15;
      corr_on = 1'b1;
      r_ticks = '0;
      l_ticks = '0;
      r_drive = '0;
      l_drive = '0;
      r_period = 8'd30;
      l_period = 8'd30;
      centre = '0;
      r_phase = '0;
      l_phase = '0;
      last_err = '0;
      mismatches = 0;
      checked = 0;
      ticks_seen = 0;
      samples_seen = 0;
      r_steps = 0;
      l_steps = 0;
    endfunction

    function void set_register(logic [swst_pkg::CfgIdxW-1:0] idx,
                               logic [swst_pkg::ValW-1:0] val);
      if (idx == swst_pkg::RegBasePeriod) base_period = val;
      else if (idx == swst_pkg::RegWallThreshold) wall_level = val;
      else if (idx == swst_pkg::RegCorrectionEnable) corr_on = val[0];
    endfunction

    function logic [swst_pkg::ValW-1:0] coil_step(logic [1:0] ph);
      case (ph)
        2'd0: return 8'h99;
        2'd1: return 8'h33;
        2'd2: return 8'h66;
        default: return 8'hCC;
      endcase
    endfunction

    function int ambient_free(logic [swst_pkg::ValW-1:0] lit, logic [swst_pkg::ValW-1:0] dark);
      return (lit > dark) ? int'(lit) - int'(dark) : 0;
    endfunction

    function logic [swst_pkg::ValW-1:0] stretched_period(int mag);
      int p;
      p = int'(base_period) + mag / 8;
      return (p > 255) ? 8'd255 : p[swst_pkg::ValW-1:0];
    endfunction

    function void note_input(swst_pkg::item_kind_e kind, logic [swst_pkg::InDataW-1:0] d);
      swst_pkg::result_t r;
      int lv, rv, cv, err;
      r = '0;
      if (kind == swst_pkg::KindTick) begin
        ticks_seen++;
        r_ticks = r_ticks + 8'd1;
        if (r_ticks > r_period && d[0]) begin
          r_ticks = '0;
          r_drive = coil_step(r_phase);
          r_phase = r_phase + 2'd1;
          r.right_stepped = 1'b1;
          r_steps++;
        end
        l_ticks = l_ticks + 8'd1;
        if (l_ticks > l_period && d[1]) begin
          l_ticks = '0;
          l_drive = coil_step(l_phase);
          l_phase = l_phase + 2'd1;
          r.left_stepped = 1'b1;
          l_steps++;
        end
      end else begin
        samples_seen++;
        lv = ambient_free(d[9:2], d[17:10]);
        rv = ambient_free(d[25:18], d[33:26]);
        cv = int'(centre);
        if (lv < int'(wall_level)) begin
          err = cv - rv;
          centre = 8'((cv + rv) / 2);
        end else if (rv < int'(wall_level)) begin
          err = lv - cv;
          centre = 8'((lv + cv) / 2);
        end else begin
          err = lv - rv;
          centre = 8'((lv + rv) / 2);
        end
        last_err = 9'(err);
        if (corr_on) begin
          if (err > 0) r_period = stretched_period(err);
          else if (err < 0) l_period = stretched_period(-err);
        end
      end
      r.right_pattern = r_drive;
      r.left_pattern = l_drive;
      r.steer_error = last_err;
      r.right_period_now = r_period;
      r.left_period_now = l_period;
      pending_words.push_back(r);
    endfunction

    function void report(string field, int got, int want);
      $display("mismatch in %s on result %0d: got %0d, want %0d", field, checked, got, want);
      mismatches++;
    endfunction

    function void check_result(logic [swst_pkg::OutDataW-1:0] d);
      swst_pkg::result_t got, want;
      got = swst_pkg::result_t'(d[ResW-1:0]);
      if (pending_words.size() == 0) begin
        report("unexpected result", int'(d[ResW-1:0]), 0);
        return;
      end
      want = pending_words.pop_front();
      if (got.right_pattern != want.right_pattern)
        report("right_pattern", got.right_pattern, want.right_pattern);
      if (got.left_pattern != want.left_pattern)
        report("left_pattern", got.left_pattern, want.left_pattern);
      if (got.right_stepped != want.right_stepped)
        report("right_stepped", got.right_stepped, want.right_stepped);
      if (got.left_stepped != want.left_stepped)
        report("left_stepped", got.left_stepped, want.left_stepped);
      if (got.steer_error != want.steer_error)
        report("steer_error", int'(got.steer_error), int'(want.steer_error));
      if (got.right_period_now != want.right_period_now)
        report("right_period_now", got.right_period_now, want.right_period_now);
      if (got.left_period_now != want.left_period_now)
        report("left_period_now", got.left_period_now, want.left_period_now);
      if (d[swst_pkg::OutDataW-1:ResW] != '0)
        report("padding", int'(d[swst_pkg::OutDataW-1:ResW]), 0);
      checked++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [swst_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [swst_pkg::OutDataW-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [swst_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [swst_pkg::ValW-1:0] cfg_data_i = '0;

  steer_scoreboard sb;
  bit calm = 1'b0;
  int ready_hold = 0;
  int settings_used = 0;

  stepper_pair_wall_steering dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [swst_pkg::InDataW-1:0] pack_word(logic ren, logic len,
      logic [swst_pkg::ValW-1:0] ll, logic [swst_pkg::ValW-1:0] ld,
      logic [swst_pkg::ValW-1:0] rl, logic [swst_pkg::ValW-1:0] rd);
    return {{(swst_pkg::InDataW-34){1'b0}}, rd, rl, ld, ll, len, ren};
  endfunction

  // {dark, lit}: open random, near a wall, or dark above lit
  function automatic logic [15:0] reading_pair();
    int mode;
    logic [swst_pkg::ValW-1:0] lit, dark;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      lit = 8'($urandom_range(0, 255));
      dark = 8'($urandom_range(0, 255));
    end else if (mode < 8) begin
      lit = 8'($urandom_range(0, 255));
      dark = 8'($urandom_range(0, 20));
    end else begin
      lit = 8'($urandom_range(0, 100));
      dark = lit + 8'($urandom_range(1, 155));
    end
    return {dark, lit};
  endfunction

  // result side stall pattern
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm || $urandom_range(0, 1)) begin
      m_axis_tready <= 1'b1;
      ready_hold <= calm ? 0 : $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b0;
      ready_hold <= idle_len() - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input(swst_pkg::item_kind_e'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata);
    end
  end

  task automatic push_item(input swst_pkg::item_kind_e kind,
                           input logic [swst_pkg::InDataW-1:0] d);
    int gap;
    gap = calm ? 0 : ($urandom_range(0, 1) ? 0 : idle_len());
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [swst_pkg::CfgIdxW-1:0] idx,
                           input logic [swst_pkg::ValW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_register(idx, val);
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    push_item(swst_pkg::KindTick, pack_word(1, 1, 0, 0, 0, 0));
    push_item(swst_pkg::KindTick, pack_word(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // both walls, left dark above lit, right wall absent, zero error
    push_item(swst_pkg::KindSensor, pack_word(1, 1, 200, 10, 100, 5));
    push_item(swst_pkg::KindSensor, pack_word(0, 0, 5, 200, 60, 0));
    push_item(swst_pkg::KindSensor, pack_word(1, 0, 120, 0, 3, 0));
    push_item(swst_pkg::KindSensor, pack_word(0, 1, 80, 0, 80, 0));
    push_item(swst_pkg::KindSensor, pack_word(1, 1, 255, 0, 255, 0));
    push_item(swst_pkg::KindSensor, pack_word(0, 0, 0, 0, 0, 0));
    push_item(swst_pkg::KindSensor, pack_word(0, 0, 255, 255, 0, 255));
    settle();
    write_reg(swst_pkg::RegBasePeriod, 8'd0);
    write_reg(swst_pkg::RegWallThreshold, 8'd0);
    write_reg(RegUnused, 8'hFF);
    // zero periods: step on every enabled tick
    push_item(swst_pkg::KindSensor, pack_word(0, 0, 3, 0, 0, 0));
    push_item(swst_pkg::KindSensor, pack_word(0, 0, 0, 0, 3, 0));
    push_item(swst_pkg::KindTick, pack_word(1, 1, 0, 0, 0, 0));
    push_item(swst_pkg::KindTick, pack_word(1, 0, 0, 0, 0, 0));
    push_item(swst_pkg::KindTick, pack_word(0, 1, 0, 0, 0, 0));
    push_item(swst_pkg::KindTick, pack_word(1, 1, 0, 0, 0, 0));
    push_item(swst_pkg::KindTick, pack_word(1, 1, 0, 0, 0, 0));
    push_item(swst_pkg::KindTick, pack_word(1, 1, 0, 0, 0, 0));
    settle();
    write_reg(swst_pkg::RegBasePeriod, 8'd255);
    write_reg(swst_pkg::RegWallThreshold, 8'd255);
    // saturating periods
    push_item(swst_pkg::KindSensor, pack_word(1, 1, 255, 0, 0, 0));
    push_item(swst_pkg::KindSensor, pack_word(1, 1, 0, 0, 255, 0));
    push_item(swst_pkg::KindTick, pack_word(1, 1, 0, 0, 0, 0));
    push_item(swst_pkg::KindTick, pack_word(1, 1, 0, 0, 0, 0));
    push_item(swst_pkg::KindTick, pack_word(1, 1, 0, 0, 0, 0));
    settle();
    write_reg(swst_pkg::RegCorrectionEnable, 8'd0);
    push_item(swst_pkg::KindSensor, pack_word(0, 0, 200, 0, 0, 0));
    push_item(swst_pkg::KindTick, pack_word(1, 1, 0, 0, 0, 0));
  endtask

  task automatic run_random(input int count);
    logic [15:0] lp, rp;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      lp = reading_pair();
      rp = reading_pair();
      push_item(($urandom_range(0, 9) < 7) ? swst_pkg::KindTick : swst_pkg::KindSensor,
                pack_word($urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                          lp[7:0], lp[15:8], rp[7:0], rp[15:8]));
    end
  endtask

  initial begin
    int base_tab[6] = '{30, 0, 255, 8, 250, 30};
    int wall_tab[6] = '{15, 0, 255, 60, 0, 15};
    int corr_tab[6] = '{1, 1, 1, 1, 1, 0};
    logic [swst_pkg::ValW-1:0] bp, wt;
    logic ce;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < 8; p++) begin
      settle();
      if (p < 6) begin
        bp = 8'(base_tab[p]);
        wt = 8'(wall_tab[p]);
        ce = corr_tab[p][0];
      end else begin
        bp = 8'($urandom_range(0, 40));
        wt = 8'($urandom_range(0, 255));
        ce = 1'($urandom_range(0, 1));
      end
      write_reg(swst_pkg::RegWallThreshold, wt);
      write_reg(swst_pkg::RegBasePeriod, bp);
      write_reg(swst_pkg::RegCorrectionEnable, {7'd0, ce});
      if (p == 3) write_reg(RegUnused, 8'($urandom_range(0, 255)));
      settings_used++;
      run_random(205);
    end
    calm = 1'b0;
    settle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d ticks and %0d sensor samples over %0d random settings",
             sb.ticks_seen, sb.samples_seen, settings_used);
    $display("%0d right and %0d left steps, %0d results checked",
             sb.r_steps, sb.l_steps, sb.checked);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d results outstanding", sb.pending_words.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
